>>> design/sle_pkg.sv
// shared types and constants for the sequential list engine
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int ModeW  = 2;
  localparam int PosW   = 9;
  localparam int ValW   = 32;
  localparam int StatW  = 2;
  localparam int FoundW = 8;
  localparam int LenW   = 9;

  localparam logic [ModeW-1:0] MODE_INS  = 2'd0;
  localparam logic [ModeW-1:0] MODE_DEL  = 2'd1;
  localparam logic [ModeW-1:0] MODE_SRCH = 2'd2;
  localparam logic [ModeW-1:0] MODE_NOP  = 2'd3;

  typedef enum logic [1:0] {
    OP_INS,
    OP_DEL,
    OP_SRCH,
    OP_NOP
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_DEL,
    ST_SRCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic [PosW-1:0]       position;
    logic [ValW-1:0]       value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_if_t;

endpackage

`default_nettype wire

>>> design/sle_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/sle_front.sv
// input side: accepts transfers, decodes the operation and queues commands
`timescale 1ns / 1ps
`default_nettype none

module sle_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [47:0]                  s_axis_tdata,
  input  wire logic [sle_pkg::ModeW-1:0]    s_axis_tuser,
  output sle_pkg::cmd_if_t                  cmd_o,
  input  wire logic                         pop_i
);

  import sle_pkg::*;

  cmd_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       in_cmd;
  logic       push;
  logic       pop;

  always_comb begin
    in_cmd.position = s_axis_tdata[PosW-1:0];
    in_cmd.value    = s_axis_tdata[PosW+ValW-1:PosW];
    unique case (s_axis_tuser)
      MODE_INS:  in_cmd.op = OP_INS;
      MODE_DEL:  in_cmd.op = OP_DEL;
      MODE_SRCH: in_cmd.op = OP_SRCH;
      MODE_NOP:  in_cmd.op = OP_NOP;
      default:   in_cmd.op = OP_NOP;
    endcase
  end

  assign s_axis_tready = (fill_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (fill_q != 2'd0);

  assign cmd_o.valid = (fill_q != 2'd0);
  assign cmd_o.cmd   = slot_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

>>> design/sle_back.sv
// execution side: shifts, scans and checks against the store, holds the result
`timescale 1ns / 1ps
`default_nettype none

module sle_back #(
  parameter int Depth = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sle_pkg::cmd_if_t                  cmd_i,
  output logic                                   pop_o,
  output logic                                   ram_we_o,
  output logic [$clog2(Depth)-1:0]               ram_waddr_o,
  output logic [sle_pkg::ValW-1:0]               ram_wdata_o,
  output logic                                   ram_re_o,
  output logic [$clog2(Depth)-1:0]               ram_raddr_o,
  input  wire logic [sle_pkg::ValW-1:0]          ram_rdata_i,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [23:0]                            m_axis_tdata,
  output logic [sle_pkg::StatW-1:0]              m_axis_tuser
);

  import sle_pkg::*;

  localparam int AW   = $clog2(Depth);
  localparam int CW   = $clog2(Depth + 1);
  localparam int CMPW = ((CW > PosW) ? CW : PosW) + 1;
  localparam int FXW  = (AW > FoundW) ? AW : FoundW;
  localparam int LXW  = (CW > LenW) ? CW : LenW;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   tgt_q, tgt_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   padr_q, padr_d;
  logic [ValW-1:0] val_q, val_d;
  status_e         rstat_q, rstat_d;
  logic [AW-1:0]   rfound_q, rfound_d;
  logic            ov_q, ov_d;
  status_e         ostat_q, ostat_d;
  logic [FoundW-1:0] ofound_q, ofound_d;
  logic [LenW-1:0] olen_q, olen_d;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [FXW-1:0]  found_x;
  logic [LXW-1:0]  len_x;

  assign pos_x   = CMPW'(cmd_i.cmd.position);
  assign cnt_x   = CMPW'(cnt_q);
  assign found_x = FXW'(rfound_q);
  assign len_x   = LXW'(cnt_q);

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {7'd0, olen_q, ofound_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    pend_d      = 1'b0;
    padr_d      = padr_q;
    val_d       = val_q;
    rstat_d     = rstat_q;
    rfound_d    = rfound_q;
    ov_d        = ov_q && !m_axis_tready;
    ostat_d     = ostat_q;
    ofound_d    = ofound_q;
    olen_d      = olen_q;
    pop_o       = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = padr_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = AW'(idx_q);

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          pop_o    = 1'b1;
          val_d    = cmd_i.cmd.value;
          rfound_d = '0;
          rstat_d  = STAT_OK;
          unique case (cmd_i.cmd.op)
            OP_INS: begin
              if (cnt_q == CW'(Depth)) begin
                rstat_d = STAT_FULL;
                state_d = ST_DONE;
              end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                rstat_d = STAT_RANGE;
                state_d = ST_DONE;
              end else begin
                idx_d   = cnt_q;
                tgt_d   = CW'(cmd_i.cmd.position - PosW'(1));
                state_d = ST_INS;
              end
            end
            OP_DEL: begin
              if (pos_x == '0 || pos_x > cnt_x) begin
                rstat_d = STAT_RANGE;
                state_d = ST_DONE;
              end else begin
                idx_d   = CW'(cmd_i.cmd.position);
                state_d = ST_DEL;
              end
            end
            OP_SRCH: begin
              idx_d   = '0;
              state_d = ST_SRCH;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_INS: begin
        if (pend_q) begin
          ram_we_o = 1'b1;
        end
        if (idx_q > tgt_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AW'(idx_q - CW'(1));
          pend_d      = 1'b1;
          padr_d      = AW'(idx_q);
          idx_d       = idx_q - CW'(1);
        end else if (!pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = AW'(tgt_q);
          ram_wdata_o = val_q;
          cnt_d       = cnt_q + CW'(1);
          state_d     = ST_DONE;
        end
      end
      ST_DEL: begin
        if (pend_q) begin
          ram_we_o = 1'b1;
        end
        if (idx_q < cnt_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AW'(idx_q);
          pend_d      = 1'b1;
          padr_d      = AW'(idx_q - CW'(1));
          idx_d       = idx_q + CW'(1);
        end else if (!pend_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_DONE;
        end
      end
      ST_SRCH: begin
        if (pend_q && ram_rdata_i == val_q) begin
          rfound_d = padr_q;
          state_d  = ST_DONE;
        end else if (idx_q < cnt_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AW'(idx_q);
          pend_d      = 1'b1;
          padr_d      = AW'(idx_q);
          idx_d       = idx_q + CW'(1);
        end else if (!pend_q) begin
          rstat_d = STAT_NOTFOUND;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d     = 1'b1;
          ostat_d  = rstat_q;
          ofound_d = found_x[FoundW-1:0];
          olen_d   = len_x[LenW-1:0];
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    tgt_q    <= tgt_d;
    padr_q   <= padr_d;
    val_q    <= val_d;
    rstat_q  <= rstat_d;
    rfound_q <= rfound_d;
    ostat_q  <= ostat_d;
    ofound_q <= ofound_d;
    olen_q   <= olen_d;
  end

endmodule

`default_nettype wire

>>> design/sequential_list_engine.sv
// top level of the sequential list engine: command queue, executor and list store
//
// channel  dir  tdata (low bit up)                     tuser
// s_axis   in   position[8:0], value[40:9], zero fill   mode[1:0]
// m_axis   out  found_index[7:0], list_length[16:8],    status[1:0]
//               zero fill
//
// insert shifts the entries from position to the end up one place, delete
// shifts those after position down one place, search scans from index 0 until
// a match; a rejected or unused operation goes straight to the result; the
// single store port pair moves one entry per cycle
// reset empties the list at once, no clearing pass
// a two-entry command queue keeps taking transfers while a result waits on m_axis
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_engine #(
  parameter int DEPTH = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [47:0]                s_axis_tdata,  // position, value
  input  wire logic [sle_pkg::ModeW-1:0]  s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // found_index, list_length
  output logic [sle_pkg::StatW-1:0]       m_axis_tuser   // status
);

  import sle_pkg::*;

  localparam int AW = $clog2(DEPTH);

  cmd_if_t         cmd;
  logic            pop;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ValW-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [ValW-1:0] ram_rdata;

  sle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_o         (cmd),
    .pop_i         (pop)
  );

  sle_ram #(
    .Width (ValW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sle_back #(
    .Depth (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .pop_o         (pop),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> sim/tb_sequential_list_engine.sv
// self-checking testbench for the sequential list engine: directed table plus biased random ops
`timescale 1ns / 1ps
`default_nettype none

module tb_sequential_list_engine;
  import sle_pkg::*;

  localparam int DEPTH = 256;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 300;
  localparam int RandomItems = 1525;
  localparam int IdlePercent = 29;
  localparam int PrintLimit = 40;

  typedef struct packed {
    op_e             op;
    logic [PosW-1:0] position;
    logic [ValW-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    status_e           status;
    logic [FoundW-1:0] found_index;
    logic [LenW-1:0]   list_length;
  } list_result_t;

  typedef struct packed {
    list_cmd_t    cmd;
    logic         typed;
    list_result_t want;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // position[8:0], value[40:9], zero fill
  logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // found_index[7:0], list_length[16:8], zero fill
  logic [1:0]  m_axis_tuser;        // status[1:0]

  logic [ValW-1:0] list_words [DEPTH];
  int              list_len = 0;
  list_result_t    pending_results [$];
  int              mismatch_count = 0;
  int              stall_cycles = 0;
  bit              calm = 1'b0;

  always #2 clk_i = ~clk_i;

  sequential_list_engine #(.DEPTH(DEPTH)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < IdlePercent);
  endfunction

  // list model: applies one op and returns the result it produces
  function automatic list_result_t apply_list_op(list_cmd_t cmd);
    list_result_t res;
    int pos;
    int k;
    res = '{STAT_OK, '0, '0};
    pos = int'(cmd.position);
    case (cmd.op)
      OP_INS: begin
        if (list_len >= DEPTH) begin
          res.status = STAT_FULL;
        end else if (pos < 1 || pos > list_len + 1) begin
          res.status = STAT_RANGE;
        end else begin
          for (k = list_len; k >= pos; k--) list_words[k] = list_words[k-1];
          list_words[pos-1] = cmd.value;
          list_len++;
        end
      end
      OP_DEL: begin
        if (pos < 1 || pos > list_len) begin
          res.status = STAT_RANGE;
        end else begin
          for (k = pos; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      OP_SRCH: begin
        res.status = STAT_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_words[k] == cmd.value) begin
            res.status = STAT_OK;
            res.found_index = k[FoundW-1:0];
            break;
          end
        end
      end
      default: ;
    endcase
    res.list_length = list_len[LenW-1:0];
    return res;
  endfunction

  task automatic issue_command(input list_cmd_t cmd, input logic typed, input list_result_t want);
    list_result_t predicted;
    while (take_break()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, cmd.value, cmd.position};
    s_axis_tuser  <= cmd.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = apply_list_op(cmd);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PrintLimit)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [PosW-1:0] pick_position(op_e op);
    int hi;
    int r;
    hi = (op == OP_INS) ? list_len + 1 : list_len;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return PosW'($urandom_range(511));
    if (r < 18) return PosW'(hi + 1);
    if (r < 30) return PosW'(1);
    if (r < 42) return PosW'(hi);
    if (hi < 1) return PosW'(1);
    return PosW'($urandom_range(hi, 1));
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'h0000_0000;
    if (r < 15) return 32'h7fff_ffff;
    if (r < 20) return 32'h8000_0000;
    if (r < 25) return 32'hffff_ffff;
    if (r < 40) return ValW'($urandom_range(15));
    return $urandom;
  endfunction

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", m_axis_tuser, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[7:0] != want.found_index)
          report_mismatch("found_index", m_axis_tdata[7:0], want.found_index);
        if (m_axis_tdata[16:8] != want.list_length)
          report_mismatch("list_length", m_axis_tdata[16:8], want.list_length);
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t plan [0:20];
    list_cmd_t     cmd;
    bit            growing;
    int            full_seen;
    int            empty_seen;
    int            r;

    plan = '{
      '{'{OP_SRCH, 9'd0,   32'h0000_0000}, 1'b1, '{STAT_NOTFOUND, 8'd0, 9'd0}},
      '{'{OP_DEL,  9'd1,   32'h0000_0000}, 1'b1, '{STAT_RANGE,    8'd0, 9'd0}},
      '{'{OP_INS,  9'd0,   32'h1234_5678}, 1'b1, '{STAT_RANGE,    8'd0, 9'd0}},
      '{'{OP_INS,  9'd2,   32'h1234_5678}, 1'b1, '{STAT_RANGE,    8'd0, 9'd0}},
      '{'{OP_INS,  9'd1,   32'h8000_0000}, 1'b1, '{STAT_OK,       8'd0, 9'd1}},
      '{'{OP_INS,  9'd2,   32'h7fff_ffff}, 1'b1, '{STAT_OK,       8'd0, 9'd2}},
      '{'{OP_INS,  9'd1,   32'h0000_0000}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_INS,  9'd511, 32'hffff_ffff}, 1'b1, '{STAT_RANGE,    8'd0, 9'd3}},
      '{'{OP_SRCH, 9'd0,   32'h7fff_ffff}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_SRCH, 9'd511, 32'h8000_0000}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_SRCH, 9'd0,   32'h0001_2345}, 1'b1, '{STAT_NOTFOUND, 8'd0, 9'd3}},
      '{'{OP_INS,  9'd4,   32'hffff_ffff}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_INS,  9'd2,   32'h0000_0000}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_SRCH, 9'd0,   32'h0000_0000}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_NOP,  9'd511, 32'hffff_ffff}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_DEL,  9'd0,   32'h0000_0000}, 1'b1, '{STAT_RANGE,    8'd0, 9'd5}},
      '{'{OP_DEL,  9'd6,   32'h0000_0000}, 1'b1, '{STAT_RANGE,    8'd0, 9'd5}},
      '{'{OP_DEL,  9'd5,   32'hffff_ffff}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_DEL,  9'd1,   32'h0000_0000}, 1'b0, '{STAT_OK,       8'd0, 9'd0}},
      '{'{OP_DEL,  9'd511, 32'h0000_0000}, 1'b1, '{STAT_RANGE,    8'd0, 9'd3}},
      '{'{OP_SRCH, 9'd0,   32'h8000_0000}, 1'b0, '{STAT_OK,       8'd0, 9'd0}}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) issue_command(plan[i].cmd, plan[i].typed, plan[i].want);
    hold_until_drained();

    // grow to full, shrink to empty, repeat; most positions valid, some out of range
    growing = 1'b1;
    full_seen = 0;
    empty_seen = 0;
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 700 && n < 900);
      if (n == 1000) hold_until_drained();
      if (growing && list_len == DEPTH && full_seen >= 6) begin
        growing = 1'b0;
        full_seen = 0;
      end else if (!growing && list_len == 0 && empty_seen >= 4) begin
        growing = 1'b1;
        empty_seen = 0;
      end
      r = $urandom_range(99);
      if (r < (growing ? 70 : 10)) cmd.op = OP_INS;
      else if (r < (growing ? 80 : 70)) cmd.op = OP_DEL;
      else if (r < 97) cmd.op = OP_SRCH;
      else cmd.op = OP_NOP;
      if (cmd.op == OP_INS && list_len == DEPTH) full_seen++;
      if (cmd.op == OP_DEL && list_len == 0) empty_seen++;
      if (cmd.op == OP_SRCH || cmd.op == OP_NOP) cmd.position = PosW'($urandom_range(511));
      else cmd.position = pick_position(cmd.op);
      if (cmd.op == OP_SRCH && list_len > 0 && $urandom_range(99) < 60)
        cmd.value = list_words[$urandom_range(list_len - 1)];
      else
        cmd.value = pick_value();
      issue_command(cmd, 1'b0, '{STAT_OK, '0, '0});
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/sle_pkg.sv
design/sle_ram.sv
design/sle_front.sv
design/sle_back.sv
design/sequential_list_engine.sv
sim/tb_sequential_list_engine.sv
